// ===== sv/mgv_pkg.sv =====
// ----------------------------------------------------------------------------
// mgv_pkg
// shared widths, codes and the pipeline item type of the velocity correction
// ----------------------------------------------------------------------------
package mgv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int GAMMA_BITS    = 12;
  localparam int UNIT_BITS     = 20;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] GAMMA_RST = 14'd6827;

  localparam logic [29:0] VOL_K = 30'd1025347913;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_RAMP = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  // widths sized for the largest fraction width
  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int SUM_W  = 67;
  localparam int GP_W   = 46;
  localparam int VP_W   = 54;
  localparam int VX_W   = 94;
  localparam int NUM_W  = 82;
  localparam int REM_W  = 33;
  localparam int DN_W   = 33;
  localparam int DN2_W  = 66;
  localparam int RAD_W  = 32;
  localparam int RAD2_W = 64;
  localparam int RAD3_W = 96;
  localparam int CS_W   = 41;
  localparam int CS2_W  = 82;
  localparam int A_W    = 43;
  localparam int RDIV_W = 38;
  localparam int RREM_W = 64;
  localparam int U_W    = 21;
  localparam int UREM_W = 53;
  localparam int C_W    = 42;
  localparam int V_W    = 44;

  typedef struct packed {
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
    logic [2:0][31:0]           vel;
    logic [GP_W-1:0]            gp;
    logic [VP_W-1:0]            vp0;
    logic [VP_W-1:0]            vp1;
    logic [2:0][SQ_W-1:0]       sq;
    logic [31:0]                rho;
    logic [VX_W-1:0]            vx;
    logic [NUM_W-1:0]           num;
    logic [SUM_W-1:0]           sum;
    logic [REM_W-1:0]           rem;
    logic [NUM_W-1:0]           quo;
    logic [DN_W-1:0]            dn;
    logic [DN2_W-1:0]           dn2;
    logic [RAD_W-1:0]           rad;
    logic [RAD2_W-1:0]          rad2;
    logic [RAD3_W-1:0]          rad3;
    logic [1:0]                 mode;
    logic [RREM_W-1:0]          rrem;
    logic [RDIV_W-1:0]          rdiv;
    logic [U_W-1:0]             ramp;
    logic [2:0][UREM_W-1:0]     urem;
    logic [2:0][U_W-1:0]        u;
    logic [CS_W-1:0]            cs;
    logic [CS2_W-1:0]           cs2;
    logic [2:0][C_W-1:0]        c1;
    logic [2:0][C_W-1:0]        c2;
    logic [2:0][31:0]           gv;
  } mgv_item_t;

endpackage

// ===== sv/mgv_in_if.sv =====
// ----------------------------------------------------------------------------
// mgv_in_if
// cell beat channel: generator, centroid, volume and fluid state
// ----------------------------------------------------------------------------
interface mgv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] gen_pos_x;
  logic [31:0] gen_pos_y;
  logic [31:0] gen_pos_z;
  logic [31:0] centroid_x;
  logic [31:0] centroid_y;
  logic [31:0] centroid_z;
  logic [47:0] cell_volume;
  logic [31:0] fluid_vel_x;
  logic [31:0] fluid_vel_y;
  logic [31:0] fluid_vel_z;
  logic [31:0] fluid_pressure;
  logic [31:0] fluid_density;

  modport source (
    output valid, gen_pos_x, gen_pos_y, gen_pos_z, centroid_x, centroid_y, centroid_z,
    output cell_volume, fluid_vel_x, fluid_vel_y, fluid_vel_z, fluid_pressure,
    output fluid_density,
    input  ready
  );
  modport sink (
    input  valid, gen_pos_x, gen_pos_y, gen_pos_z, centroid_x, centroid_y, centroid_z,
    input  cell_volume, fluid_vel_x, fluid_vel_y, fluid_vel_z, fluid_pressure,
    input  fluid_density,
    output ready
  );
endinterface

// ===== sv/mgv_out_if.sv =====
// ----------------------------------------------------------------------------
// mgv_out_if
// result beat channel: generator velocity and correction mode
// ----------------------------------------------------------------------------
interface mgv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] gen_vel_x;
  logic [31:0] gen_vel_y;
  logic [31:0] gen_vel_z;
  logic [1:0]  correction_mode;

  modport source (
    output valid, gen_vel_x, gen_vel_y, gen_vel_z, correction_mode,
    input  ready
  );
  modport sink (
    input  valid, gen_vel_x, gen_vel_y, gen_vel_z, correction_mode,
    output ready
  );
endinterface

// ===== sv/mgv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mgv_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface mgv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mgv_pkg::CFG_IDX_W-1:0]    index;
  logic [mgv_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mgv_front.sv =====
// ----------------------------------------------------------------------------
// mgv_front
// offsets, squares, volume scaling and sound speed numerator (three stages)
// ----------------------------------------------------------------------------
module mgv_front #(
  parameter int FRAC_BITS = mgv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              enable_i,
  input  logic [mgv_pkg::CFG_DATA_W-1:0]    gamma_i,
  mgv_in_if.sink                            in_i,
  output mgv_pkg::mgv_item_t                item_o,
  output logic                              vld_o
);

  localparam int VXL = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
  localparam int VXR = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
  localparam int NSH = 2 * FRAC_BITS - mgv_pkg::GAMMA_BITS;
  localparam int P_W = 78;

  mgv_pkg::mgv_item_t s_d [3];
  mgv_pkg::mgv_item_t s_q [3];
  logic [2:0]         vld_q;

  assign in_i.ready = adv_i;

  always_comb begin
    logic [2:0][31:0] gp_a;
    logic [2:0][31:0] cn_a;
    logic signed [32:0] d;
    logic [P_W-1:0] p;
    gp_a = {in_i.gen_pos_z, in_i.gen_pos_y, in_i.gen_pos_x};
    cn_a = {in_i.centroid_z, in_i.centroid_y, in_i.centroid_x};
    s_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({cn_a[i][31], cn_a[i]}) - $signed({gp_a[i][31], gp_a[i]});
      s_d[0].neg[i] = d[32];
      s_d[0].mag[i] = d[32] ? 33'(-d) : 33'(d);
    end
    s_d[0].vel = {in_i.fluid_vel_z, in_i.fluid_vel_y, in_i.fluid_vel_x};
    s_d[0].rho = in_i.fluid_density;
    s_d[0].gp  = mgv_pkg::GP_W'(gamma_i) * mgv_pkg::GP_W'(in_i.fluid_pressure);
    s_d[0].vp0 = mgv_pkg::VP_W'(in_i.cell_volume[23:0]) * mgv_pkg::VP_W'(mgv_pkg::VOL_K);
    s_d[0].vp1 = mgv_pkg::VP_W'(in_i.cell_volume[47:24]) * mgv_pkg::VP_W'(mgv_pkg::VOL_K);

    s_d[1] = s_q[0];
    for (int i = 0; i < 3; i++) begin
      s_d[1].sq[i] = mgv_pkg::SQ_W'(s_q[0].mag[i]) * mgv_pkg::SQ_W'(s_q[0].mag[i]);
    end
    p = P_W'(s_q[0].vp0) + (P_W'(s_q[0].vp1) << 24);
    s_d[1].vx  = (mgv_pkg::VX_W'(p) << VXL) >> VXR;
    s_d[1].num = mgv_pkg::NUM_W'(s_q[0].gp) << NSH;

    s_d[2] = s_q[1];
    s_d[2].sum = mgv_pkg::SUM_W'(s_q[1].sq[0]) + mgv_pkg::SUM_W'(s_q[1].sq[1])
               + mgv_pkg::SUM_W'(s_q[1].sq[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], in_i.valid & enable_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q <= s_d;
    end
  end

  assign item_o = s_q[2];
  assign vld_o  = vld_q[2];

`ifndef SYNTH
  a_drop_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !enable_i |=> !vld_q[0])
    else $error("beat entered while disabled");
`endif

endmodule

// ===== sv/mgv_root_bank.sv =====
// ----------------------------------------------------------------------------
// mgv_root_bank
// one bit per stage: offset square root, radius cube root, p*gamma/rho quotient
// ----------------------------------------------------------------------------
module mgv_root_bank #(
  parameter int FRAC_BITS = mgv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  mgv_pkg::mgv_item_t item_i,
  input  logic               vld_i,
  output mgv_pkg::mgv_item_t item_o,
  output logic               vld_o
);

  localparam int QN  = 34 + 2 * FRAC_BITS;
  localparam int T2W = mgv_pkg::DN2_W + 2;
  localparam int T3W = mgv_pkg::RAD3_W + 2;
  localparam int R2W = mgv_pkg::RAD2_W + 2;

  mgv_pkg::mgv_item_t st [QN+1];
  logic [QN:0]        vld;

  assign st[0]  = item_i;
  assign vld[0] = vld_i;

  for (genvar k = 0; k < QN; k++) begin : g_stage
    localparam int QB = QN - 1 - k;
    localparam int DB = (k < mgv_pkg::DN_W) ? mgv_pkg::DN_W - 1 - k : 0;
    localparam int CB = (k < mgv_pkg::RAD_W) ? mgv_pkg::RAD_W - 1 - k : 0;

    mgv_pkg::mgv_item_t nx;
    mgv_pkg::mgv_item_t s_q;
    logic               vld_q;

    always_comb begin
      logic [mgv_pkg::REM_W:0] rs;
      logic [T2W-1:0] t2;
      logic [T3W-1:0] t3;
      logic [T3W-1:0] r2s;
      logic [T3W-1:0] r1s;
      nx = st[k];
      rs = {st[k].rem, st[k].num[QB]};
      if (rs >= (mgv_pkg::REM_W+1)'(st[k].rho)) begin
        nx.rem     = mgv_pkg::REM_W'(rs - (mgv_pkg::REM_W+1)'(st[k].rho));
        nx.quo[QB] = 1'b1;
      end else begin
        nx.rem = mgv_pkg::REM_W'(rs);
      end
      t2 = T2W'(st[k].dn2) + (T2W'(st[k].dn) << (DB + 1)) + (T2W'(1) << (2 * DB));
      if (k < mgv_pkg::DN_W && t2 <= T2W'(st[k].sum)) begin
        nx.dn[DB] = 1'b1;
        nx.dn2    = mgv_pkg::DN2_W'(t2);
      end
      r2s = T3W'(st[k].rad2) << CB;
      r1s = T3W'(st[k].rad) << (2 * CB);
      t3  = T3W'(st[k].rad3) + r2s + (r2s << 1) + r1s + (r1s << 1) + (T3W'(1) << (3 * CB));
      if (k < mgv_pkg::RAD_W && t3 <= T3W'(st[k].vx)) begin
        nx.rad[CB] = 1'b1;
        nx.rad3    = mgv_pkg::RAD3_W'(t3);
        nx.rad2    = mgv_pkg::RAD2_W'(R2W'(st[k].rad2) + (R2W'(st[k].rad) << (CB + 1))
                   + (R2W'(1) << (2 * CB)));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (adv_i) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_q <= nx;
      end
    end

    assign st[k+1]  = s_q;
    assign vld[k+1] = vld_q;
  end

  assign item_o = st[QN];
  assign vld_o  = vld[QN];

endmodule

// ===== sv/mgv_corr_bank.sv =====
// ----------------------------------------------------------------------------
// mgv_corr_bank
// mode decision, then one bit per stage: sound speed root, ramp and unit vector
// ----------------------------------------------------------------------------
module mgv_corr_bank #(
  parameter int FRAC_BITS = mgv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  mgv_pkg::mgv_item_t item_i,
  input  logic               vld_i,
  output mgv_pkg::mgv_item_t item_o,
  output logic               vld_o
);

  localparam int QN  = 34 + 2 * FRAC_BITS;
  localparam int CSN = (QN + 1) / 2;
  localparam int TW  = mgv_pkg::CS2_W + 2;

  mgv_pkg::mgv_item_t st [CSN+2];
  logic [CSN+1:0]     vld;
  mgv_pkg::mgv_item_t dec_d;
  mgv_pkg::mgv_item_t dec_q;
  logic               dec_vld_q;

  always_comb begin
    logic [mgv_pkg::A_W-1:0] a;
    logic [mgv_pkg::A_W-1:0] lo;
    logic [mgv_pkg::A_W-1:0] hi;
    a  = mgv_pkg::A_W'(item_i.dn) * mgv_pkg::A_W'(1000);
    lo = mgv_pkg::A_W'(item_i.rad) * mgv_pkg::A_W'(225);
    hi = mgv_pkg::A_W'(item_i.rad) * mgv_pkg::A_W'(275);
    dec_d = item_i;
    if (item_i.dn == '0 || a <= lo) begin
      dec_d.mode = mgv_pkg::MODE_NONE;
    end else if (a < hi) begin
      dec_d.mode = mgv_pkg::MODE_RAMP;
    end else begin
      dec_d.mode = mgv_pkg::MODE_FULL;
    end
    dec_d.rrem = mgv_pkg::RREM_W'(a - lo) << mgv_pkg::UNIT_BITS;
    dec_d.rdiv = mgv_pkg::RDIV_W'(item_i.rad) * mgv_pkg::RDIV_W'(50);
    for (int i = 0; i < 3; i++) begin
      dec_d.urem[i] = mgv_pkg::UREM_W'(item_i.mag[i]) << mgv_pkg::UNIT_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
    end else if (adv_i) begin
      dec_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dec_q <= dec_d;
    end
  end

  assign st[0]  = dec_q;
  assign vld[0] = dec_vld_q;

  for (genvar j = 0; j < CSN; j++) begin : g_stage
    localparam int SB = CSN - 1 - j;
    localparam int KB = (j < mgv_pkg::U_W) ? mgv_pkg::U_W - 1 - j : 0;

    mgv_pkg::mgv_item_t nx;
    mgv_pkg::mgv_item_t s_q;
    logic               vld_q;

    always_comb begin
      logic [TW-1:0]             t;
      logic [mgv_pkg::RREM_W-1:0] rd;
      logic [mgv_pkg::UREM_W-1:0] ud;
      nx = st[j];
      t  = TW'(st[j].cs2) + (TW'(st[j].cs) << (SB + 1)) + (TW'(1) << (2 * SB));
      if (t <= TW'(st[j].quo)) begin
        nx.cs[SB] = 1'b1;
        nx.cs2    = mgv_pkg::CS2_W'(t);
      end
      rd = mgv_pkg::RREM_W'(st[j].rdiv) << KB;
      ud = mgv_pkg::UREM_W'(st[j].dn) << KB;
      if (j < mgv_pkg::U_W) begin
        if (st[j].rrem >= rd) begin
          nx.rrem     = st[j].rrem - rd;
          nx.ramp[KB] = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          if (st[j].urem[i] >= ud) begin
            nx.urem[i]   = st[j].urem[i] - ud;
            nx.u[i][KB]  = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (adv_i) begin
        vld_q <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_q <= nx;
      end
    end

    assign st[j+1]  = s_q;
    assign vld[j+1] = vld_q;
  end

  assign st[CSN+1]  = st[CSN];
  assign vld[CSN+1] = vld[CSN];
  assign item_o     = st[CSN+1];
  assign vld_o      = vld[CSN+1];

endmodule

// ===== sv/mgv_back.sv =====
// ----------------------------------------------------------------------------
// mgv_back
// correction products, velocity sum with saturation and result register
// ----------------------------------------------------------------------------
module mgv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mgv_pkg::mgv_item_t item_i,
  input  logic               vld_i,
  output logic               adv_o,
  mgv_out_if.source          out_o
);

  localparam int P1_W = mgv_pkg::CS_W + mgv_pkg::U_W;
  localparam int P2_W = mgv_pkg::C_W + mgv_pkg::U_W;
  localparam logic signed [mgv_pkg::V_W-1:0] VMAX = 44'sd2147483647;
  localparam logic signed [mgv_pkg::V_W-1:0] VMIN = -44'sd2147483648;

  mgv_pkg::mgv_item_t s_d [3];
  mgv_pkg::mgv_item_t s_q [3];
  logic [2:0]         vld_q;

  assign adv_o = !vld_q[2] || out_o.ready;

  always_comb begin
    logic [mgv_pkg::CS_W-1:0] cs_eff;
    logic [mgv_pkg::U_W-1:0]  ramp_eff;
    logic signed [mgv_pkg::V_W-1:0] v;
    logic signed [mgv_pkg::V_W-1:0] c;
    s_d[0] = item_i;
    cs_eff = (item_i.rho == '0) ? '0 : item_i.cs;
    for (int i = 0; i < 3; i++) begin
      s_d[0].c1[i] = mgv_pkg::C_W'((P1_W'(cs_eff) * P1_W'(item_i.u[i])) >> mgv_pkg::UNIT_BITS);
    end

    s_d[1] = s_q[0];
    case (s_q[0].mode)
      mgv_pkg::MODE_FULL: ramp_eff = mgv_pkg::U_W'(1) << mgv_pkg::UNIT_BITS;
      mgv_pkg::MODE_RAMP: ramp_eff = s_q[0].ramp;
      default:            ramp_eff = '0;
    endcase
    for (int i = 0; i < 3; i++) begin
      s_d[1].c2[i] = mgv_pkg::C_W'((P2_W'(s_q[0].c1[i]) * P2_W'(ramp_eff))
                   >> mgv_pkg::UNIT_BITS);
    end

    s_d[2] = s_q[1];
    for (int i = 0; i < 3; i++) begin
      c = $signed({2'b00, s_q[1].c2[i]});
      v = mgv_pkg::V_W'($signed(s_q[1].vel[i])) + (s_q[1].neg[i] ? -c : c);
      if (v > VMAX) begin
        s_d[2].gv[i] = 32'h7FFF_FFFF;
      end else if (v < VMIN) begin
        s_d[2].gv[i] = 32'h8000_0000;
      end else begin
        s_d[2].gv[i] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_o) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s_q <= s_d;
    end
  end

  assign out_o.valid           = vld_q[2];
  assign out_o.gen_vel_x       = s_q[2].gv[0];
  assign out_o.gen_vel_y       = s_q[2].gv[1];
  assign out_o.gen_vel_z       = s_q[2].gv[2];
  assign out_o.correction_mode = s_q[2].mode;

`ifndef SYNTH
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !out_o.ready |=> vld_q[2] && $stable(s_q[2].gv) && $stable(s_q[2].mode))
    else $error("result changed under stall");
`endif
`ifndef SYNTH
  a_none_no_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && vld_q[0] && s_q[0].mode == mgv_pkg::MODE_NONE |=> s_q[1].c2 == '0)
    else $error("correction applied in mode none");
`endif

endmodule

// ===== sv/mesh_generator_velocity_correction.sv =====
// ----------------------------------------------------------------------------
// mesh_generator_velocity_correction
// throughput: one beat per cycle while the output is not stalled; each root or quotient bit is one stage
// a stalled output freezes the whole pipe, no beat is lost or repeated
// reset clears all valid bits, gamma to 6827 and disables results
// ----------------------------------------------------------------------------
module mesh_generator_velocity_correction #(
  parameter int FRAC_BITS = mgv_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mgv_cfg_if.sink    cfg_i,
  mgv_in_if.sink     in_i,
  mgv_out_if.source  out_o
);

  logic [mgv_pkg::CFG_DATA_W-1:0] gamma_q;
  logic                           enable_q;
  logic                           adv;
  mgv_pkg::mgv_item_t             fr_item, ra_item, cb_item;
  logic                           fr_vld, ra_vld, cb_vld;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q  <= mgv_pkg::GAMMA_RST;
      enable_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        mgv_pkg::CFG_GAMMA:  gamma_q  <= cfg_i.data;
        mgv_pkg::CFG_ENABLE: enable_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  mgv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .enable_i (enable_q),
    .gamma_i  (gamma_q),
    .in_i     (in_i),
    .item_o   (fr_item),
    .vld_o    (fr_vld)
  );

  mgv_root_bank #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (fr_item),
    .vld_i  (fr_vld),
    .item_o (ra_item),
    .vld_o  (ra_vld)
  );

  mgv_corr_bank #(.FRAC_BITS(FRAC_BITS)) u_corr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (ra_item),
    .vld_i  (ra_vld),
    .item_o (cb_item),
    .vld_o  (cb_vld)
  );

  mgv_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (cb_item),
    .vld_i  (cb_vld),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule
